FILE: sv/cbcm_pkg.sv
// Shared types and constants for the circle versus box collision manifold.
package cbcm_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;

  localparam logic [17:0] NORM_POS = 18'h10000;
  localparam logic [17:0] NORM_NEG = 18'h30000;
  localparam logic [30:0] PEN_MAX  = 31'h7FFFFFFF;

  // Per-transaction data carried beside the root and divide pipelines
  typedef struct packed {
    logic        hit;
    logic        ctr_in_box;
    logic        sgn_x;
    logic        sgn_y;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] r2;
    logic [17:0] in_nx;
    logic [17:0] in_ny;
    logic [30:0] in_pen;
  } cbcm_side_t;

endpackage

FILE: sv/cbcm_sqrt_pipe.sv
// Pipelined 64-bit integer square root, one result bit per stage.
module cbcm_sqrt_pipe
  import cbcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] in_rad,
  input  cbcm_side_t  in_side,
  output logic        out_valid,
  output logic [31:0] out_root,
  output cbcm_side_t  out_side
);

  logic             vld_r  [SQRT_STEPS];
  logic [33:0]      rem_r  [SQRT_STEPS];
  logic [31:0]      root_r [SQRT_STEPS];
  logic [63:0]      rad_r  [SQRT_STEPS];
  cbcm_side_t       side_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_st
    logic        vld_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    cbcm_side_t  side_in;
    logic [35:0] trial;
    logic [35:0] tst;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial = {rem_in, rad_in[63-2*i -: 2]};
      tst   = {2'b00, root_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (trial >= tst) begin
          rem_r[i]  <= 34'(trial - tst);
          root_r[i] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[i]  <= trial[33:0];
          root_r[i] <= {root_in[30:0], 1'b0};
        end
        rad_r[i]  <= rad_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

FILE: sv/cbcm_norm_div.sv
// Pipelined restoring divider for both normal components, rounded to nearest.
module cbcm_norm_div
  import cbcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] in_den,
  input  cbcm_side_t  in_side,
  output logic        out_valid,
  output logic [16:0] out_qx,
  output logic [16:0] out_qy,
  output logic [31:0] out_den,
  output cbcm_side_t  out_side
);

  logic             vld_r  [DIV_STEPS];
  logic [31:0]      remx_r [DIV_STEPS];
  logic [31:0]      remy_r [DIV_STEPS];
  logic [16:0]      qx_r   [DIV_STEPS];
  logic [16:0]      qy_r   [DIV_STEPS];
  logic [48:0]      numx_r [DIV_STEPS];
  logic [48:0]      numy_r [DIV_STEPS];
  logic [31:0]      den_r  [DIV_STEPS];
  cbcm_side_t       side_r [DIV_STEPS];

  logic [48:0] numx0;
  logic [48:0] numy0;

  // Numerator is |d| * 65536 + s/2 so the quotient comes out rounded
  always_comb begin
    numx0 = {1'b0, in_side.ax, 16'h0000} + {18'h0, in_den[31:1]};
    numy0 = {1'b0, in_side.ay, 16'h0000} + {18'h0, in_den[31:1]};
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_st
    logic        vld_in;
    logic [31:0] remx_in;
    logic [31:0] remy_in;
    logic [16:0] qx_in;
    logic [16:0] qy_in;
    logic [48:0] numx_in;
    logic [48:0] numy_in;
    logic [31:0] den_in;
    cbcm_side_t  side_in;
    logic [32:0] tx;
    logic [32:0] ty;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign remx_in = numx0[48:17];
      assign remy_in = numy0[48:17];
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign numx_in = numx0;
      assign numy_in = numy0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign remx_in = remx_r[i-1];
      assign remy_in = remy_r[i-1];
      assign qx_in   = qx_r[i-1];
      assign qy_in   = qy_r[i-1];
      assign numx_in = numx_r[i-1];
      assign numy_in = numy_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      tx = {remx_in, numx_in[16-i]};
      ty = {remy_in, numy_in[16-i]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (tx >= {1'b0, den_in}) begin
          remx_r[i] <= 32'(tx - {1'b0, den_in});
          qx_r[i]   <= {qx_in[15:0], 1'b1};
        end else begin
          remx_r[i] <= tx[31:0];
          qx_r[i]   <= {qx_in[15:0], 1'b0};
        end
        if (ty >= {1'b0, den_in}) begin
          remy_r[i] <= 32'(ty - {1'b0, den_in});
          qy_r[i]   <= {qy_in[15:0], 1'b1};
        end else begin
          remy_r[i] <= ty[31:0];
          qy_r[i]   <= {qy_in[15:0], 1'b0};
        end
        numx_r[i] <= numx_in;
        numy_r[i] <= numy_in;
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_qx    = qx_r[DIV_STEPS-1];
  assign out_qy    = qy_r[DIV_STEPS-1];
  assign out_den   = den_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

FILE: sv/circle_box_collision_manifold_top.sv
// Circle versus axis-aligned box collision manifold, fully pipelined.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | box center, size, circle center, radius
//   out_    | output    | out_valid/out_stall | hit, normal x/y, penetration depth
//
// One transaction enters per cycle while in_stall is low; the pipeline has 4 front stages
// (clamp, abs, squares, compare), 32 square root stages, 17 divide stages
// and the output register. The whole pipeline holds while the output
// register is full and stalled; in_stall follows that condition.
// Reset clears all valid bits; no clearing pass.
module circle_box_collision_manifold_top
  import cbcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_box_center_x,
  input  logic signed [31:0] in_box_center_y,
  input  logic        [30:0] in_box_width,
  input  logic        [30:0] in_box_height,
  input  logic signed [31:0] in_circle_center_x,
  input  logic signed [31:0] in_circle_center_y,
  input  logic        [30:0] in_circle_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic        [30:0] out_penetration_depth
);

  logic adv;

  // Stage 1: clamp to the box in doubled coordinates
  logic signed [33:0] bx2, by2, cx2, cy2, lox, hix, loy, hiy, clx, cly;
  logic               s1_vld_r;
  logic signed [34:0] s1_dx_r, s1_dy_r, s1_lx_r, s1_ly_r;
  logic        [30:0] s1_w_r, s1_h_r;
  logic        [31:0] s1_r2_r;

  // Stage 2: magnitudes and overlaps
  logic        [34:0] ax, ay, alx, aly;
  logic               s2_vld_r, s2_big_r, s2_sx_r, s2_sy_r, s2_lxn_r, s2_lyn_r;
  logic        [31:0] s2_ax_r, s2_ay_r, s2_r2_r;
  logic signed [35:0] s2_ox_r, s2_oy_r;

  // Stage 3: squares
  logic signed [36:0] pen_raw;
  logic               s3_vld_r, s3_big_r, s3_sx_r, s3_sy_r, s3_selx_r, s3_lxn_r, s3_lyn_r;
  logic        [63:0] s3_sqx_r, s3_sqy_r, s3_rr_r;
  logic        [31:0] s3_ax_r, s3_ay_r, s3_r2_r;
  logic signed [36:0] s3_pen_r;

  // Stage 4: miss test and inside-box result
  logic        [64:0] dd;
  logic        [36:0] pen_half;
  logic               s4_vld_r;
  logic        [63:0] s4_dd_r;
  cbcm_side_t         s4_side_r, s4_side_nxt;

  logic               sq_vld;
  logic        [31:0] sq_root;
  cbcm_side_t         sq_side;

  logic               dv_vld;
  logic        [16:0] dv_qx, dv_qy;
  logic        [31:0] dv_den;
  cbcm_side_t         dv_side;

  logic               out_valid_r, out_hit_r;
  logic        [17:0] out_nx_r, out_ny_r, nx_nxt, ny_nxt;
  logic        [30:0] out_pen_r, pen_nxt;
  logic        [31:0] pen_diff;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    bx2 = {in_box_center_x[31], in_box_center_x, 1'b0};
    by2 = {in_box_center_y[31], in_box_center_y, 1'b0};
    cx2 = {in_circle_center_x[31], in_circle_center_x, 1'b0};
    cy2 = {in_circle_center_y[31], in_circle_center_y, 1'b0};
    lox = bx2 - $signed({3'b000, in_box_width});
    hix = bx2 + $signed({3'b000, in_box_width});
    loy = by2 - $signed({3'b000, in_box_height});
    hiy = by2 + $signed({3'b000, in_box_height});
    if (cx2 < lox)      clx = lox;
    else if (cx2 > hix) clx = hix;
    else                clx = cx2;
    if (cy2 < loy)      cly = loy;
    else if (cy2 > hiy) cly = hiy;
    else                cly = cy2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= 35'(cx2) - 35'(clx);
      s1_dy_r <= 35'(cy2) - 35'(cly);
      s1_lx_r <= 35'(cx2) - 35'(bx2);
      s1_ly_r <= 35'(cy2) - 35'(by2);
      s1_w_r  <= in_box_width;
      s1_h_r  <= in_box_height;
      s1_r2_r <= {in_circle_radius, 1'b0};
    end
  end

  always_comb begin
    ax  = s1_dx_r[34] ? 35'(-s1_dx_r) : s1_dx_r;
    ay  = s1_dy_r[34] ? 35'(-s1_dy_r) : s1_dy_r;
    alx = s1_lx_r[34] ? 35'(-s1_lx_r) : s1_lx_r;
    aly = s1_ly_r[34] ? 35'(-s1_ly_r) : s1_ly_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_big_r <= (ax > {3'b000, s1_r2_r}) || (ay > {3'b000, s1_r2_r});
      s2_ax_r  <= ax[31:0];
      s2_ay_r  <= ay[31:0];
      s2_sx_r  <= s1_dx_r[34];
      s2_sy_r  <= s1_dy_r[34];
      s2_lxn_r <= s1_lx_r[34];
      s2_lyn_r <= s1_ly_r[34];
      s2_ox_r  <= $signed({5'b0, s1_w_r}) - $signed({1'b0, alx});
      s2_oy_r  <= $signed({5'b0, s1_h_r}) - $signed({1'b0, aly});
      s2_r2_r  <= s1_r2_r;
    end
  end

  always_comb begin
    if (s2_ox_r < s2_oy_r) pen_raw = 37'(s2_ox_r) + $signed({5'b0, s2_r2_r});
    else                   pen_raw = 37'(s2_oy_r) + $signed({5'b0, s2_r2_r});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sqx_r  <= s2_ax_r * s2_ax_r;
      s3_sqy_r  <= s2_ay_r * s2_ay_r;
      s3_rr_r   <= s2_r2_r * s2_r2_r;
      s3_big_r  <= s2_big_r;
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
      s3_r2_r   <= s2_r2_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_lxn_r  <= s2_lxn_r;
      s3_lyn_r  <= s2_lyn_r;
      s3_selx_r <= s2_ox_r < s2_oy_r;
      s3_pen_r  <= pen_raw;
    end
  end

  always_comb begin
    dd = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
    // drop negative depth, halve, then saturate
    pen_half = s3_pen_r[36] ? 37'h0 : {1'b0, s3_pen_r[36:1]};
    s4_side_nxt.hit        = !(s3_big_r || dd[64] || (dd[63:0] > s3_rr_r));
    s4_side_nxt.ctr_in_box = dd[63:0] == 64'h0;
    s4_side_nxt.sgn_x      = s3_sx_r;
    s4_side_nxt.sgn_y      = s3_sy_r;
    s4_side_nxt.ax         = s3_ax_r;
    s4_side_nxt.ay         = s3_ay_r;
    s4_side_nxt.r2         = s3_r2_r;
    s4_side_nxt.in_nx      = '0;
    s4_side_nxt.in_ny      = '0;
    if (s3_selx_r) s4_side_nxt.in_nx = s3_lxn_r ? NORM_NEG : NORM_POS;
    else           s4_side_nxt.in_ny = s3_lyn_r ? NORM_NEG : NORM_POS;
    s4_side_nxt.in_pen = (pen_half > {6'b0, PEN_MAX}) ? PEN_MAX : pen_half[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dd_r   <= dd[63:0];
      s4_side_r <= s4_side_nxt;
    end
  end

  cbcm_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s4_vld_r),
    .in_rad    (s4_dd_r),
    .in_side   (s4_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  cbcm_norm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_vld),
    .in_den    (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_vld),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_den   (dv_den),
    .out_side  (dv_side)
  );

  always_comb begin
    pen_diff = dv_side.r2 - dv_den;
    nx_nxt   = '0;
    ny_nxt   = '0;
    pen_nxt  = '0;
    if (dv_side.hit) begin
      if (dv_side.ctr_in_box) begin
        nx_nxt  = dv_side.in_nx;
        ny_nxt  = dv_side.in_ny;
        pen_nxt = dv_side.in_pen;
      end else begin
        nx_nxt  = dv_side.sgn_x ? 18'(-{1'b0, dv_qx}) : {1'b0, dv_qx};
        ny_nxt  = dv_side.sgn_y ? 18'(-{1'b0, dv_qy}) : {1'b0, dv_qy};
        pen_nxt = pen_diff[31:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= dv_side.hit;
      out_nx_r  <= nx_nxt;
      out_ny_r  <= ny_nxt;
      out_pen_r <= pen_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_normal_x          = out_nx_r;
  assign out_normal_y          = out_ny_r;
  assign out_penetration_depth = out_pen_r;

endmodule
